/* hw/rtl/czr_pkg.sv */
// Shared widths, register indexes and types for the crop/zoom pixel remapper.
package czr_pkg;

  // field and datapath widths
  localparam int PIX_W      = 12;  // pixel index, input and output
  localparam int SIZE_W     = 13;  // frame size register
  localparam int PER_W      = SIZE_W + 1;  // mirror period, twice the size
  localparam int START_W    = 32;  // signed window origin
  localparam int STEP_W     = 19;  // unsigned step
  localparam int PROD_W     = PIX_W + STEP_W;
  localparam int SUM_W      = PROD_W + 3;  // origin plus product, never wraps
  localparam int MAX_SIZE   = 4096;  // frame size saturation

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_FILL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd6;

  // flags that ride along the remainder pipeline, lane 0 is x, lane 1 is y
  typedef struct packed {
    logic       fill;
    logic [1:0] neg;
  } czr_side_t;

endpackage

/* hw/rtl/czr_mod_pipe.sv */
// Pipelined restoring remainder unit, two lanes (x and y), three bits per stage.
module czr_mod_pipe
  import czr_pkg::*;
#(
  parameter int MAG_W = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0][MAG_W-1:0]       in_mag,
  input  czr_side_t                   in_side,
  input  logic [1:0][PER_W-1:0]       per,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0][PER_W-1:0]       out_rem,
  output czr_side_t                   out_side
);

  localparam int BPS  = 3;
  localparam int NSTG = (MAG_W + BPS - 1) / BPS;
  localparam int DV_W = NSTG * BPS;

  logic [NSTG-1:0]              v_r;
  logic [NSTG-1:0]              rdy;
  logic [1:0][DV_W-1:0]         dvd_r  [NSTG];
  logic [1:0][PER_W-1:0]        rem_r  [NSTG];
  czr_side_t                    side_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic                  vin;
    logic                  rdn;
    logic [1:0][DV_W-1:0]  d_in;
    logic [1:0][PER_W-1:0] r_in;
    czr_side_t             sd_in;
    logic [1:0][DV_W-1:0]  d_nxt;
    logic [1:0][PER_W-1:0] r_nxt;

    if (s == 0) begin : g_head
      assign vin     = in_valid;
      assign d_in[0] = DV_W'(in_mag[0]);
      assign d_in[1] = DV_W'(in_mag[1]);
      assign r_in    = '0;
      assign sd_in   = in_side;
    end else begin : g_body
      assign vin   = v_r[s-1];
      assign d_in  = dvd_r[s-1];
      assign r_in  = rem_r[s-1];
      assign sd_in = side_r[s-1];
    end

    if (s == NSTG - 1) begin : g_tail
      assign rdn = out_ready;
    end else begin : g_mid
      assign rdn = rdy[s+1];
    end

    assign rdy[s] = !v_r[s] || rdn;

    // shift in the next dividend bits, subtract the period when it fits
    always_comb begin
      logic [PER_W:0]   t;
      logic [DV_W-1:0]  d;
      logic [PER_W-1:0] r;
      for (int l = 0; l < 2; l++) begin
        d = d_in[l];
        r = r_in[l];
        for (int b = 0; b < BPS; b++) begin
          t = {r, d[DV_W-1]};
          d = d << 1;
          if (t >= {1'b0, per[l]}) begin
            r = PER_W'(t - {1'b0, per[l]});
          end else begin
            r = t[PER_W-1:0];
          end
        end
        d_nxt[l] = d;
        r_nxt[l] = r;
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= vin;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (rdy[s] && vin) begin
        dvd_r[s]  <= d_nxt;
        rem_r[s]  <= r_nxt;
        side_r[s] <= sd_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_rem   = rem_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

  // a finished remainder is always below its period
  a_rem_below_per: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rem[0] < per[0]) && (out_rem[1] < per[1]))
    else $error("remainder not below period");

endmodule

/* hw/rtl/crop_zoom_pixel_remap_top.sv */
// Top level of the crop/zoom pixel remapper: config registers and address pipeline.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: out_x, out_y
//  out_    | out | out_tvalid/tready  | tdata: src_x, src_y; tuser: fill_black
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One word per clock sustained while the output is not stalled. Words pass through
// stages A, B and C, then the remainder pipeline that retires three quotient bits
// per stage for the mirror fold, then output stage D.
// Synchronous active-low reset empties the pipeline and restores register defaults.
// Every stage has its own valid and loads when the next one can take its word,
// so bubbles close up under an output stall and nothing is lost or repeated.
module crop_zoom_pixel_remap_top
  import czr_pkg::*;
#(
  parameter int FRAC_BITS = 16  // fraction bits of start and step, 8 to 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*PIX_W-1:0]    in_tdata,   // [11:0] out_x, [23:12] out_y
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*PIX_W-1:0]    out_tdata,  // [11:0] src_x, [23:12] src_y
  output logic                  out_tuser,  // [0] fill_black
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = SUM_W - FRAC_BITS;  // signed source coordinate width

  // configuration, sizes held already clamped to [1, MAX_SIZE]
  logic [SIZE_W-1:0]        w_eff_r;
  logic [SIZE_W-1:0]        h_eff_r;
  logic                     black_fill_r;
  logic signed [START_W-1:0] start_x_r;
  logic signed [START_W-1:0] start_y_r;
  logic [STEP_W-1:0]        step_x_r;
  logic [STEP_W-1:0]        step_y_r;
  logic [SIZE_W-1:0]        size_in;
  logic [SIZE_W-1:0]        size_clamp;
  logic [1:0][PER_W-1:0]    per;
  logic [1:0][SIZE_W-1:0]   size;

  // pipeline stages ahead of the remainder unit
  logic                      a_v_r;
  logic [1:0][PROD_W-1:0]    a_prod_r;
  logic                      b_v_r;
  logic [1:0][CW-1:0]        b_coord_r;
  logic                      c_v_r;
  logic [1:0][CW-1:0]        c_mag_r;
  czr_side_t                 c_side_r;
  logic                      a_rdy;
  logic                      b_rdy;
  logic                      c_rdy;
  logic                      d_rdy;

  logic [1:0][SUM_W-1:0]     b_coord_sum;
  logic [1:0][CW-1:0]        c_mag_nxt;
  czr_side_t                 c_side_nxt;

  // remainder unit and output stage
  logic                      m_in_ready;
  logic                      m_out_valid;
  logic [1:0][PER_W-1:0]     m_rem;
  czr_side_t                 m_side;
  logic [2*PIX_W-1:0]        out_tdata_nxt;
  logic [2*PIX_W-1:0]        out_tdata_r;
  logic                      out_tuser_r;
  logic                      out_tvalid_r;

  // size register clamp at write time
  assign size_in = cfg_data[SIZE_W-1:0];
  always_comb begin
    if (size_in == '0) begin
      size_clamp = SIZE_W'(1);
    end else if (32'(size_in) > 32'(MAX_SIZE)) begin
      size_clamp = SIZE_W'(MAX_SIZE);
    end else begin
      size_clamp = size_in;
    end
  end

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r      <= SIZE_W'(640);
      h_eff_r      <= SIZE_W'(480);
      black_fill_r <= 1'b0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      step_x_r     <= STEP_W'(65536);
      step_y_r     <= STEP_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_eff_r      <= size_clamp;
        REG_FRAME_HEIGHT: h_eff_r      <= size_clamp;
        REG_BLACK_FILL:   black_fill_r <= cfg_data[0];
        REG_START_X:      start_x_r    <= signed'(cfg_data[START_W-1:0]);
        REG_START_Y:      start_y_r    <= signed'(cfg_data[START_W-1:0]);
        REG_STEP_X:       step_x_r     <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:       step_y_r     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign size[0] = w_eff_r;
  assign size[1] = h_eff_r;
  assign per[0]  = {w_eff_r, 1'b0};
  assign per[1]  = {h_eff_r, 1'b0};

  // ready chain, each stage loads when empty or when its word moves on
  assign d_rdy     = !out_tvalid_r || out_tready;
  assign c_rdy     = !c_v_r || m_in_ready;
  assign b_rdy     = !b_v_r || c_rdy;
  assign a_rdy     = !a_v_r || b_rdy;
  assign in_tready = a_rdy;

  // stage A: index times step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_tvalid) begin
      a_prod_r[0] <= PROD_W'(in_tdata[PIX_W-1:0] * step_x_r);
      a_prod_r[1] <= PROD_W'(in_tdata[2*PIX_W-1:PIX_W] * step_y_r);
    end
  end

  // stage B: add origin, floor by dropping fraction bits
  assign b_coord_sum[0] = SUM_W'(start_x_r) + SUM_W'(a_prod_r[0]);
  assign b_coord_sum[1] = SUM_W'(start_y_r) + SUM_W'(a_prod_r[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v_r) begin
      b_coord_r[0] <= b_coord_sum[0][SUM_W-1:FRAC_BITS];
      b_coord_r[1] <= b_coord_sum[1][SUM_W-1:FRAC_BITS];
    end
  end

  // stage C: magnitude and sign for the fold, range check for black fill
  always_comb begin
    logic [1:0] inr;
    for (int l = 0; l < 2; l++) begin
      c_side_nxt.neg[l] = b_coord_r[l][CW-1];
      c_mag_nxt[l] = b_coord_r[l][CW-1] ? CW'(-b_coord_r[l]) : b_coord_r[l];
      inr[l] = !b_coord_r[l][CW-1] && (32'(b_coord_r[l]) < 32'(size[l]));
    end
    c_side_nxt.fill = black_fill_r && !(inr[0] && inr[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_v_r) begin
      c_mag_r  <= c_mag_nxt;
      c_side_r <= c_side_nxt;
    end
  end

  // |coord| mod period
  czr_mod_pipe #(
    .MAG_W (CW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_v_r),
    .in_ready  (m_in_ready),
    .in_mag    (c_mag_r),
    .in_side   (c_side_r),
    .per       (per),
    .out_valid (m_out_valid),
    .out_ready (d_rdy),
    .out_rem   (m_rem),
    .out_side  (m_side)
  );

  // stage D: floor-mod fixup for negatives, fold the upper half back
  always_comb begin
    logic [PER_W-1:0] m;
    logic [PER_W-1:0] src;
    for (int l = 0; l < 2; l++) begin
      m = (m_side.neg[l] && (m_rem[l] != '0)) ? PER_W'(per[l] - m_rem[l]) : m_rem[l];
      src = (m < {1'b0, size[l]}) ? m : PER_W'(per[l] - m - PER_W'(1));
      out_tdata_nxt[l*PIX_W +: PIX_W] = m_side.fill ? '0 : src[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (d_rdy) begin
      out_tvalid_r <= m_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy && m_out_valid) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= m_side.fill;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a black pixel carries zero coordinates
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("filled pixel with nonzero coordinates");

  // mirror mode never fills
  a_mirror_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !black_fill_r |-> !out_tuser)
    else $error("fill raised in mirror mode");

  // fetched coordinates lie inside the frame
  a_src_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (32'(out_tdata[PIX_W-1:0]) < 32'(w_eff_r)) &&
      (32'(out_tdata[2*PIX_W-1:PIX_W]) < 32'(h_eff_r)))
    else $error("source coordinate outside frame");

  // input backs up only when the output is held with a full pipeline
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

/* tb/tb_crop_zoom_pixel_remap_top.sv */
`timescale 1ns / 100ps
// Testbench for the crop/zoom pixel remapper: directed corner cases, then randomized windows.
module tb_crop_zoom_pixel_remap_top;
  import czr_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int LATENCY        = 4 + (34 - FRAC_BITS + 2) / 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;
  localparam int WINDOW_ITEMS   = 50;
  localparam logic [31:0] ONE_PIXEL = 32'd1 << FRAC_BITS;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] src_x;
    logic [PIX_W-1:0] src_y;
    logic             fill;
  } src_word_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [2*PIX_W-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*PIX_W-1:0]    out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // shadow copy of the register file, reset values
  logic [SIZE_W-1:0]         frame_w    = 13'd640;
  logic [SIZE_W-1:0]         frame_h    = 13'd480;
  logic                      black_fill = 1'b0;
  logic signed [START_W-1:0] org_x      = '0;
  logic signed [START_W-1:0] org_y      = '0;
  logic [STEP_W-1:0]         pitch_x    = 19'd65536;
  logic [STEP_W-1:0]         pitch_y    = 19'd65536;

  src_word_t src_pending[$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;

  crop_zoom_pixel_remap_top #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp_size(logic [SIZE_W-1:0] size_reg);
    longint s;
    s = longint'({1'b0, size_reg});
    if (s < 1) s = 1;
    if (s > MAX_SIZE) s = MAX_SIZE;
    return s;
  endfunction

  // floor((origin + idx * pitch) / 2^FRAC_BITS), wide so it never wraps
  function automatic longint source_pos(logic signed [START_W-1:0] origin,
                                        logic [STEP_W-1:0] pitch, logic [PIX_W-1:0] idx);
    longint sum;
    sum = longint'(origin) + longint'({1'b0, idx}) * longint'({1'b0, pitch});
    return sum >>> FRAC_BITS;
  endfunction

  // reflect into [0, size) with period 2*size
  function automatic longint mirror_pos(longint v, longint size);
    longint period;
    longint m;
    period = 2 * size;
    m = v % period;
    if (m < 0) m += period;
    return (m < size) ? m : period - 1 - m;
  endfunction

  function automatic src_word_t remap_pixel(logic [PIX_W-1:0] ox, logic [PIX_W-1:0] oy);
    src_word_t r;
    longint w, h, cx, cy;
    w  = clamp_size(frame_w);
    h  = clamp_size(frame_h);
    cx = source_pos(org_x, pitch_x, ox);
    cy = source_pos(org_y, pitch_y, oy);
    r  = '0;
    if (black_fill) begin
      if (cx < 0 || cx >= w || cy < 0 || cy >= h) begin
        r.fill = 1'b1;
      end else begin
        r.src_x = PIX_W'(cx);
        r.src_y = PIX_W'(cy);
      end
    end else begin
      r.src_x = PIX_W'(mirror_pos(cx, w));
      r.src_y = PIX_W'(mirror_pos(cy, h));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- result side
  task automatic log_mismatch(input string what, input src_word_t want, input src_word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected x=%0d y=%0d fill=%0b, got x=%0d y=%0d fill=%0b", $time,
               what, want.src_x, want.src_y, want.fill, got.src_x, got.src_y, got.fill);
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // compare each result word with the oldest expected one
  always @(posedge clk) begin : check_results
    src_word_t got;
    src_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.src_x = out_tdata[PIX_W-1:0];
      got.src_y = out_tdata[2*PIX_W-1:PIX_W];
      got.fill  = out_tuser;
      if (src_pending.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = src_pending.pop_front();
        if ((got.src_x !== want.src_x) || (got.src_y !== want.src_y) ||
            (got.fill !== want.fill))
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // entered and left at a falling edge; valid stays high for the next word
  task automatic send_word(input logic [PIX_W-1:0] ox, input logic [PIX_W-1:0] oy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {oy, ox};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    src_pending.push_back(remap_pixel(ox, oy));
    @(negedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (src_pending.size() != 0) @(negedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  frame_w    = data[SIZE_W-1:0];
      REG_FRAME_HEIGHT: frame_h    = data[SIZE_W-1:0];
      REG_BLACK_FILL:   black_fill = data[0];
      REG_START_X:      org_x      = data[START_W-1:0];
      REG_START_Y:      org_y      = data[START_W-1:0];
      REG_STEP_X:       pitch_x    = data[STEP_W-1:0];
      REG_STEP_Y:       pitch_y    = data[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_window(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] black, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] stx,
                              input logic [31:0] sty);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BLACK_FILL, black);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_STEP_X, stx);
    write_reg(REG_STEP_Y, sty);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // reset defaults: 640x480 mirror, unit step, origin zero
  task automatic test_reset_window();
    send_word(12'd0, 12'd0);
    send_word(12'd4095, 12'd4095);
    send_word(12'd639, 12'd479);
    send_word(12'd640, 12'd480);
    send_word(12'd1279, 12'd959);
    send_word(12'd1280, 12'd960);
  endtask

  // zero size acts as one, oversize saturates, extreme origins and steps
  task automatic test_size_limits();
    apply_window(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE_PIXEL, ONE_PIXEL);
    send_word(12'd5, 12'd7);
    send_word(12'd4095, 12'd0);
    apply_window(32'hFFFF_FFFF, 32'd4097, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0007_FFFF, 32'h0007_FFFF);
    send_word(12'd4095, 12'd4095);
    send_word(12'd0, 12'd0);
    send_word(12'd1, 12'd2);
  endtask

  // black edges: just inside, just outside on the left, right and bottom sides, fractional origin
  task automatic test_edge_fill();
    apply_window(32'd640, 32'd480, 32'd1, 32'hFFFF_FFFF, 32'd0, ONE_PIXEL, ONE_PIXEL);
    send_word(12'd0, 12'd0);
    send_word(12'd1, 12'd0);
    send_word(12'd640, 12'd479);
    send_word(12'd641, 12'd0);
    send_word(12'd5, 12'd480);
    apply_window(32'd4096, 32'd4096, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_word(12'd100, 12'd100);
    apply_window(32'd1, 32'd1, 32'd1, 32'h0000_FFFF, 32'h0000_8000, 32'd0, 32'h0007_FFFF);
    send_word(12'd4095, 12'd0);
    send_word(12'd0, 12'd1);
  endtask

  // write to an index with no register behind it must change nothing
  task automatic test_unused_index();
    apply_window(32'd3, 32'd5, 32'd0, 32'h8000_0000, 32'hFFF0_0000, 32'h0001_8000,
                 32'h0000_4000);
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_word(12'd3, 12'd4);
    send_word(12'd4095, 12'd1);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 16);
      3:       return $urandom_range(701, MAX_SIZE);
      default: return $urandom_range(17, 700);
    endcase
  endfunction

  // mostly windows that land on the frame, some with every bit random but the fill select
  task automatic random_window(input logic black);
    logic [31:0] w, h, sx, sy, stx, sty, flag;
    if ($urandom_range(0, 3) == 0) begin
      flag    = $urandom;
      flag[0] = black;
      apply_window($urandom, $urandom, flag, $urandom, $urandom, $urandom, $urandom);
    end else begin
      w   = pick_size();
      h   = pick_size();
      sx  = $urandom_range(0, 3 * w * ONE_PIXEL) - w * ONE_PIXEL;
      sy  = $urandom_range(0, 3 * h * ONE_PIXEL) - h * ONE_PIXEL;
      stx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4 * ONE_PIXEL);
      sty = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4 * ONE_PIXEL);
      apply_window(w, h, {31'd0, black}, sx, sy, stx, sty);
    end
  endtask

  // four idle profiles, four windows each, mirror and black alternating
  task automatic test_random_windows();
    int idle_tab[4]  = '{0, 69, 0, 25};
    int stall_tab[4] = '{0, 0, 69, 25};
    logic [PIX_W-1:0] ox, oy;
    for (int phase = 0; phase < 4; phase++) begin
      for (int win = 0; win < 4; win++) begin
        random_window(win[0]);
        send_idle_pct  = idle_tab[phase];
        sink_stall_pct = stall_tab[phase];
        for (int n = 0; n < WINDOW_ITEMS; n++) begin
          ox = $urandom_range(0, 1) ? PIX_W'($urandom) : PIX_W'($urandom_range(0, 255));
          oy = $urandom_range(0, 1) ? PIX_W'($urandom) : PIX_W'($urandom_range(0, 255));
          send_word(ox, oy);
        end
      end
    end
    send_idle_pct  = 0;
    sink_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_size_limits();
    test_edge_fill();
    test_unused_index();
    test_random_windows();
    settle();
    repeat (2 * LATENCY) @(negedge clk);
    mismatch_count += src_pending.size();
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/czr_pkg.sv
hw/rtl/czr_mod_pipe.sv
hw/rtl/crop_zoom_pixel_remap_top.sv
tb/tb_crop_zoom_pixel_remap_top.sv
